@@ hdl/sgft_pkg.sv @@
package sgft_pkg;

    localparam int MaxNodes = 256;

    localparam logic [1:0] CfgNodesX = 2'd0;
    localparam logic [1:0] CfgNodesY = 2'd1;
    localparam logic [1:0] CfgNodesZ = 2'd2;

    localparam logic [1:0] AxisX = 2'd0;
    localparam logic [1:0] AxisY = 2'd1;
    localparam logic [1:0] AxisZ = 2'd2;

    localparam logic [2:0] BidInterior = 3'd6;

    typedef struct packed {
        logic [8:0]  nx;
        logic [8:0]  ny;
        logic [8:0]  nz;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [7:0]  cz;
        logic [16:0] nxy;
        logic [16:0] pxy;
        logic [16:0] pyx;
        logic [15:0] pcc;
        logic [23:0] nfx;
        logic [24:0] nfxy;
        logic [25:0] total;
    } t_geom;

    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic [1:0] axis;
        logic [7:0] k;
        logic [8:0] den2;
    } t_ctx;

    typedef struct packed {
        t_ctx        ctx;
        logic [23:0] num;
        logic [16:0] den;
        logic [7:0]  quo;
    } t_div;

endpackage

@@ hdl/sgft_geom.sv @@
module sgft_geom (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [8:0]           i_cfg_data,
    output sgft_pkg::t_geom      o_geom
);

    logic [8:0]  r_cfg_x, r_cfg_y, r_cfg_z;
    logic [8:0]  r_nx, r_ny, r_nz, n_nx, n_ny, n_nz;
    logic [7:0]  r_cx, r_cy, r_cz;
    logic [16:0] r_nxy, r_pxy, r_pyx;
    logic [15:0] r_pcc;
    logic [23:0] r_nfx, r_nfy, r_nfz;
    logic [24:0] r_nfxy;
    logic [25:0] r_total;

    localparam logic [8:0] EffMax = 9'(sgft_pkg::MaxNodes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_x <= 9'd2;
            r_cfg_y <= 9'd2;
            r_cfg_z <= 9'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sgft_pkg::CfgNodesX: r_cfg_x <= i_cfg_data;
                sgft_pkg::CfgNodesY: r_cfg_y <= i_cfg_data;
                sgft_pkg::CfgNodesZ: r_cfg_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_nx = (r_cfg_x < 9'd2) ? 9'd2 : (r_cfg_x > EffMax) ? EffMax : r_cfg_x;
        n_ny = (r_cfg_y < 9'd2) ? 9'd2 : (r_cfg_y > EffMax) ? EffMax : r_cfg_y;
        n_nz = (r_cfg_z < 9'd2) ? 9'd2 : (r_cfg_z > EffMax) ? EffMax : r_cfg_z;
    end

    always_ff @(posedge i_clk) begin
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_nz    <= n_nz;
        r_cx    <= 8'(n_nx - 9'd1);
        r_cy    <= 8'(n_ny - 9'd1);
        r_cz    <= 8'(n_nz - 9'd1);
        r_nxy   <= 17'(17'(r_nx) * 17'(r_ny));
        r_pxy   <= 17'(17'(r_nx) * 17'(r_cy));
        r_pyx   <= 17'(17'(r_cx) * 17'(r_ny));
        r_pcc   <= 16'(16'(r_cx) * 16'(r_cy));
        r_nfx   <= 24'(26'(r_pxy) * 26'(r_cz));
        r_nfy   <= 24'(26'(r_pyx) * 26'(r_cz));
        r_nfz   <= 24'(26'(r_pcc) * 26'(r_nz));
        r_nfxy  <= 25'(25'(r_nfx) + 25'(r_nfy));
        r_total <= 26'(26'(r_nfx) + 26'(r_nfy) + 26'(r_nfz));
    end

    always_comb begin
        o_geom.nx    = r_nx;
        o_geom.ny    = r_ny;
        o_geom.nz    = r_nz;
        o_geom.cx    = r_cx;
        o_geom.cy    = r_cy;
        o_geom.cz    = r_cz;
        o_geom.nxy   = r_nxy;
        o_geom.pxy   = r_pxy;
        o_geom.pyx   = r_pyx;
        o_geom.pcc   = r_pcc;
        o_geom.nfx   = r_nfx;
        o_geom.nfxy  = r_nfxy;
        o_geom.total = r_total;
    end

endmodule

@@ hdl/sgft_div_cell.sv @@
module sgft_div_cell #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sgft_pkg::t_div i_d,
    output sgft_pkg::t_div o_d
);

    sgft_pkg::t_div r_d, n_d;
    logic [24:0]    w_shift;
    logic           w_take;

    always_comb begin
        w_shift = 25'(i_d.den) << BIT;
        w_take  = {1'b0, i_d.num} >= w_shift;
        n_d     = i_d;
        if (w_take) begin
            n_d.num      = 24'({1'b0, i_d.num} - w_shift);
            n_d.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.ctx.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ hdl/structured_grid_face_topology_top.sv @@
// The pipeline has one stage per quotient bit in two 8-cell divider chains, plus
// delay-line, classify, product, base node and output stages up to o_valid.
// Throughput: one face per cycle; the whole pipeline stalls only while o_valid waits.
// A configuration write takes effect for faces transferred on the next cycle on.
// Reset (synchronous, active low) clears all valid bits and sets node counts to 2.
module structured_grid_face_topology_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [25:0] i_face_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_orientation,
    output logic [23:0] o_owner_cell,
    output logic [23:0] o_neighbour_cell,
    output logic        o_has_neighbour,
    output logic [2:0]  o_boundary_id,
    output logic [23:0] o_vertex_a,
    output logic [23:0] o_vertex_b,
    output logic [23:0] o_vertex_c,
    output logic [23:0] o_vertex_d,
    output logic        o_index_invalid
);

    sgft_pkg::t_geom w_geom;
    logic            w_en;

    sgft_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom)
    );

    assign o_cfg_ready = 1'b1;
    assign w_en        = !o_valid || i_ready;
    assign o_ready     = w_en;

    // delay line while derived geometry settles after a write
    logic [25:0] r_dly_f [4];
    logic [3:0]  r_dly_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_v <= '0;
        end else if (w_en) begin
            r_dly_v <= {r_dly_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly_f[0] <= i_face_number;
            r_dly_f[1] <= r_dly_f[0];
            r_dly_f[2] <= r_dly_f[1];
            r_dly_f[3] <= r_dly_f[2];
        end
    end

    // classify
    sgft_pkg::t_div r_cls, n_cls;
    logic [25:0]    w_f;

    always_comb begin
        w_f                = r_dly_f[3];
        n_cls              = '0;
        n_cls.ctx.valid    = r_dly_v[3];
        n_cls.ctx.invalid  = w_f >= w_geom.total;
        if (w_f < 26'(w_geom.nfx)) begin
            n_cls.ctx.axis = sgft_pkg::AxisX;
            n_cls.ctx.den2 = w_geom.nx;
            n_cls.num      = 24'(w_f);
            n_cls.den      = w_geom.pxy;
        end else if (w_f < 26'(w_geom.nfxy)) begin
            n_cls.ctx.axis = sgft_pkg::AxisY;
            n_cls.ctx.den2 = 9'(w_geom.cx);
            n_cls.num      = 24'(w_f - 26'(w_geom.nfx));
            n_cls.den      = w_geom.pyx;
        end else begin
            n_cls.ctx.axis = sgft_pkg::AxisZ;
            n_cls.ctx.den2 = 9'(w_geom.cx);
            n_cls.num      = 24'(w_f - 26'(w_geom.nfxy));
            n_cls.den      = 17'(w_geom.pcc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls.ctx.valid <= 1'b0;
        end else if (w_en) begin
            r_cls <= n_cls;
        end
    end

    // k = f / plane size, then j = remainder / row size
    sgft_pkg::t_div w_a [9];
    sgft_pkg::t_div w_b [9];

    assign w_a[0] = r_cls;

    always_comb begin
        w_b[0]         = '0;
        w_b[0].ctx     = w_a[8].ctx;
        w_b[0].ctx.k   = w_a[8].quo;
        w_b[0].num     = 24'(w_a[8].num[16:0]);
        w_b[0].den     = 17'(w_a[8].ctx.den2);
    end

    for (genvar g = 0; g < 8; g++) begin : g_chain
        sgft_div_cell #(.BIT(7 - g)) u_cell_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_a[g]),
            .o_d     (w_a[g + 1])
        );
        sgft_div_cell #(.BIT(7 - g)) u_cell_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_b[g]),
            .o_d     (w_b[g + 1])
        );
    end

    // products and wall tests
    logic        r_p_valid, r_p_invalid, r_p_min, r_p_max;
    logic [1:0]  r_p_axis;
    logic [7:0]  r_p_i;
    logic [16:0] r_p_jnx;
    logic [23:0] r_p_knxy;
    logic [15:0] r_p_jcx;
    logic [23:0] r_p_kpcc;
    logic [7:0]  w_i, w_j, w_k, w_pos, w_lim;

    always_comb begin
        w_i = w_b[8].num[7:0];
        w_j = w_b[8].quo;
        w_k = w_b[8].ctx.k;
        case (w_b[8].ctx.axis)
            sgft_pkg::AxisX: begin w_pos = w_i; w_lim = w_geom.cx; end
            sgft_pkg::AxisY: begin w_pos = w_j; w_lim = w_geom.cy; end
            default:         begin w_pos = w_k; w_lim = w_geom.cz; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_b[8].ctx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_invalid <= w_b[8].ctx.invalid;
            r_p_axis    <= w_b[8].ctx.axis;
            r_p_min     <= w_pos == 8'd0;
            r_p_max     <= w_pos == w_lim;
            r_p_i       <= w_i;
            r_p_jnx     <= 17'(17'(w_j) * 17'(w_geom.nx));
            r_p_knxy    <= 24'(25'(w_k) * 25'(w_geom.nxy));
            r_p_jcx     <= 16'(16'(w_j) * 16'(w_geom.cx));
            r_p_kpcc    <= 24'(24'(w_k) * 24'(w_geom.pcc));
        end
    end

    // base node and cell
    logic        r_s_valid, r_s_invalid, r_s_min, r_s_max;
    logic [1:0]  r_s_axis;
    logic [23:0] r_s_v0, r_s_here, r_s_step, r_s_offb, r_s_offc;
    logic [23:0] n_s_step, n_s_offb, n_s_offc;

    always_comb begin
        case (r_p_axis)
            sgft_pkg::AxisX: begin
                n_s_step = 24'd1;
                n_s_offb = 24'(w_geom.nx);
                n_s_offc = 24'(w_geom.nxy);
            end
            sgft_pkg::AxisY: begin
                n_s_step = 24'(w_geom.cx);
                n_s_offb = 24'd1;
                n_s_offc = 24'(w_geom.nxy);
            end
            default: begin
                n_s_step = 24'(w_geom.pcc);
                n_s_offb = 24'd1;
                n_s_offc = 24'(w_geom.nx);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_en) begin
            r_s_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_invalid <= r_p_invalid;
            r_s_min     <= r_p_min;
            r_s_max     <= r_p_max;
            r_s_axis    <= r_p_axis;
            r_s_v0      <= 24'(24'(r_p_i) + 24'(r_p_jnx) + r_p_knxy);
            r_s_here    <= 24'(24'(r_p_i) + 24'(r_p_jcx) + r_p_kpcc);
            r_s_step    <= n_s_step;
            r_s_offb    <= n_s_offb;
            r_s_offc    <= n_s_offc;
        end
    end

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_axis, n_o_axis;
    logic [23:0] r_o_owner, r_o_neigh, r_o_va, r_o_vb, r_o_vc, r_o_vd;
    logic [23:0] n_o_owner, n_o_neigh, n_o_va, n_o_vb, n_o_vc, n_o_vd;
    logic        r_o_has, r_o_inv, n_o_has;
    logic [2:0]  r_o_bid, n_o_bid;

    always_comb begin
        n_o_axis  = r_s_axis;
        n_o_va    = r_s_v0;
        n_o_vb    = 24'(r_s_v0 + r_s_offb);
        n_o_vc    = 24'(r_s_v0 + r_s_offc);
        n_o_vd    = 24'(r_s_v0 + r_s_offb + r_s_offc);
        n_o_neigh = '0;
        n_o_has   = 1'b0;
        if (r_s_min) begin
            n_o_owner = r_s_here;
            n_o_bid   = {r_s_axis, 1'b0};
        end else if (r_s_max) begin
            n_o_owner = 24'(r_s_here - r_s_step);
            n_o_bid   = {r_s_axis, 1'b1};
        end else begin
            n_o_owner = 24'(r_s_here - r_s_step);
            n_o_neigh = r_s_here;
            n_o_has   = 1'b1;
            n_o_bid   = sgft_pkg::BidInterior;
        end
        if (r_s_invalid) begin
            n_o_axis  = '0;
            n_o_va    = '0;
            n_o_vb    = '0;
            n_o_vc    = '0;
            n_o_vd    = '0;
            n_o_owner = '0;
            n_o_neigh = '0;
            n_o_has   = 1'b0;
            n_o_bid   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_axis  <= n_o_axis;
            r_o_owner <= n_o_owner;
            r_o_neigh <= n_o_neigh;
            r_o_has   <= n_o_has;
            r_o_bid   <= n_o_bid;
            r_o_va    <= n_o_va;
            r_o_vb    <= n_o_vb;
            r_o_vc    <= n_o_vc;
            r_o_vd    <= n_o_vd;
            r_o_inv   <= r_s_invalid;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_orientation    = r_o_axis;
    assign o_owner_cell     = r_o_owner;
    assign o_neighbour_cell = r_o_neigh;
    assign o_has_neighbour  = r_o_has;
    assign o_boundary_id    = r_o_bid;
    assign o_vertex_a       = r_o_va;
    assign o_vertex_b       = r_o_vb;
    assign o_vertex_c       = r_o_vc;
    assign o_vertex_d       = r_o_vd;
    assign o_index_invalid  = r_o_inv;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_invalid |-> o_owner_cell == '0 && o_vertex_d == '0
            && o_has_neighbour == 1'b0)
        else $error("invalid face carries nonzero fields");

    a_interior_neigh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_invalid |->
            o_has_neighbour == (o_boundary_id == sgft_pkg::BidInterior))
        else $error("neighbour flag disagrees with boundary id");

    a_wall_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_invalid && !o_has_neighbour |->
            o_boundary_id[2:1] == o_orientation)
        else $error("wall id does not match face axis");

    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline stalled with empty output");

endmodule
